// ===== src/pmq_pkg.sv =====
// Shared types and constants for the PIR motion qualifier.
`timescale 1ns / 1ps
package pmq_pkg;

  localparam int TIME_W   = 32;
  localparam int CNT_W    = 16;
  localparam int REFR_W   = 16;
  localparam int MINH_W   = 8;
  localparam int IDX_W    = 2;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 72;

  localparam logic [REFR_W-1:0] REFRESH_RST = 16'd100;
  localparam logic [TIME_W-1:0] WINDOW_RST  = 32'd3000;
  localparam logic [MINH_W-1:0] MINH_RST    = 8'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;

  typedef enum logic [IDX_W-1:0] {
    REG_REFRESH = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_MINHITS = 2'd2,
    REG_ENABLE  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TAKE   = 1'b1
  } req_t;

  typedef struct packed {
    logic [REFR_W-1:0] refresh_ms;
    logic [TIME_W-1:0] window_ms;
    logic [MINH_W-1:0] min_hits;
    logic              sensor_enabled;
    logic              config_bad;
  } cfg_t;

  typedef struct packed {
    logic              config_bad;
    logic [TIME_W-1:0] detection_time;
    logic [CNT_W-1:0]  checks_at_event;
    logic [CNT_W-1:0]  hits_at_event;
    logic              flag_taken;
    logic              rejected;
    logic              detected;
    logic              sample_taken;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== src/pmq_cfg_regs.sv =====
// Configuration register file with the bad-configuration check.
`timescale 1ns / 1ps
module pmq_cfg_regs import pmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  logic [REFR_W-1:0] refresh_ms;
  logic [TIME_W-1:0] window_ms;
  logic [MINH_W-1:0] min_hits;
  logic              sensor_enabled;
  logic [TIME_W-1:0] min_span;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_ms     <= REFRESH_RST;
      window_ms      <= WINDOW_RST;
      min_hits       <= MINH_RST;
      sensor_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_REFRESH: refresh_ms     <= cfg_data[REFR_W-1:0];
        REG_WINDOW:  window_ms      <= cfg_data[TIME_W-1:0];
        REG_MINHITS: min_hits       <= cfg_data[MINH_W-1:0];
        REG_ENABLE:  sensor_enabled <= cfg_data[0];
      endcase
    end
  end

  // 8x16 product, never wraps in 32 bits
  assign min_span = TIME_W'(min_hits) * TIME_W'(refresh_ms);

  always_comb begin
    cfg.refresh_ms     = refresh_ms;
    cfg.window_ms      = window_ms;
    cfg.min_hits       = min_hits;
    cfg.sensor_enabled = sensor_enabled;
    cfg.config_bad     = (min_span > window_ms);
  end

endmodule

// ===== src/pmq_core.sv =====
// Qualifier state and the per-item update logic.
`timescale 1ns / 1ps
module pmq_core import pmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cfg_t              cfg,
  input  logic              req_type,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              pin_level,
  output res_t              res
);

  logic [TIME_W-1:0] last_sample_time, last_sample_time_next;
  logic [CNT_W-1:0]  check_count, check_count_next;
  logic [CNT_W-1:0]  hit_count, hit_count_next;
  logic              detection_flag, detection_flag_next;
  logic [TIME_W-1:0] last_det_time, last_det_time_next;

  logic [TIME_W-1:0] diff;
  logic              taken, hit;
  logic [CNT_W-1:0]  h1, c0, c1, c2, h2;
  logic [TIME_W-1:0] span;
  logic              over, judge, det, rej;

  always_comb begin
    diff  = now_ms - last_sample_time;
    taken = (req_t'(req_type) == REQ_SAMPLE) && (diff > TIME_W'(cfg.refresh_ms));
    hit   = cfg.sensor_enabled && pin_level;
    h1    = hit ? sat_inc(hit_count) : hit_count;
    // first hit of a run restarts the check count
    c0    = (hit && h1 == CNT_W'(1)) ? '0 : check_count;
    c1    = sat_inc(c0);
    span  = TIME_W'(cfg.refresh_ms) * TIME_W'(c1);
    over  = (span > cfg.window_ms);
    c2    = over ? CNT_W'(1) : c1;
    h2    = over ? '0 : h1;
    judge = (c2 >= CNT_W'(cfg.min_hits));
    det   = judge && (h2 >= CNT_W'(cfg.min_hits));
    rej   = judge && !det && (h2 != '0);

    last_sample_time_next = last_sample_time;
    check_count_next      = check_count;
    hit_count_next        = hit_count;
    detection_flag_next   = detection_flag;
    last_det_time_next    = last_det_time;

    if (req_t'(req_type) == REQ_TAKE) begin
      detection_flag_next = 1'b0;
    end else if (taken) begin
      last_sample_time_next = now_ms;
      check_count_next      = judge ? '0 : c2;
      hit_count_next        = judge ? '0 : h2;
      if (det) begin
        detection_flag_next = 1'b1;
        last_det_time_next  = now_ms;
      end
    end

    res.sample_taken    = taken;
    res.detected        = taken && det;
    res.rejected        = taken && rej;
    res.flag_taken      = (req_t'(req_type) == REQ_TAKE) && detection_flag;
    res.hits_at_event   = (taken && judge) ? h2 : '0;
    res.checks_at_event = (taken && judge) ? c2 : '0;
    res.detection_time  = last_det_time_next;
    res.config_bad      = cfg.config_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      check_count      <= '0;
      hit_count        <= '0;
      detection_flag   <= 1'b0;
      last_det_time    <= '0;
    end else if (step) begin
      last_sample_time <= last_sample_time_next;
      check_count      <= check_count_next;
      hit_count        <= hit_count_next;
      detection_flag   <= detection_flag_next;
      last_det_time    <= last_det_time_next;
    end
  end

endmodule

// ===== src/pir_motion_qualifier_top.sv =====
// Top level: input register, qualifier core, result register.
`timescale 1ns / 1ps
// Path: an accepted item goes from the input register through the result register
//   to m_tvalid; it waits in the input register while the result stage is stalled.
// Throughput: 1 item per cycle while m_tready is high; the state update and result
//   compute are combinational between the two registers, so items run back to back.
// Reset (rst, sync, active high): both stages empty, counters, flag and times
//   cleared, registers back to refresh 100, window 3000, min hits 3, enabled.
module pir_motion_qualifier_top import pmq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // [31:0] now_ms, [32] pin_level, [39:33] zero
  input  logic              s_tuser,   // [0] req_type
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // [0] sample_taken, [1] detected,
                                       // [2] rejected, [3] flag_taken,
                                       // [19:4] hits_at_event,
                                       // [35:20] checks_at_event,
                                       // [67:36] detection_time,
                                       // [68] config_bad, [71:69] zero
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t              cfg;
  res_t              res;
  res_t              out_res;

  // input stage
  logic              in_valid;
  logic              in_req;
  logic [TIME_W-1:0] in_now;
  logic              in_pin;
  logic              advance;

  // item moves from the input register into the result register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= s_tuser;
      in_now <= s_tdata[TIME_W-1:0];
      in_pin <= s_tdata[TIME_W];
    end
  end

  pmq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state commits only when the item leaves the input register
  pmq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cfg       (cfg),
    .req_type  (in_req),
    .now_ms    (in_now),
    .pin_level (in_pin),
    .res       (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res};

  // an empty result stage never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result stage");

  // a detection is always a taken sample and never a rejection
  a_det_consistent: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.detected) |-> (out_res.sample_taken && !out_res.rejected))
    else $error("detection without taken sample");

  // a take item carries no sample result
  a_take_exclusive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.flag_taken) |-> (!out_res.sample_taken && !out_res.detected))
    else $error("flag taken on a sample item");

  // a rejection always carries nonzero hit and check counts
  a_event_counts: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.rejected) |-> (out_res.hits_at_event != '0 &&
      out_res.checks_at_event != '0))
    else $error("rejection with empty counts");

endmodule
